// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("checker assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("checker assertion failed");

`endif

// ===== rtl/bq_pkg.sv =====
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types, constants and helpers of the biquad IIR section.
// ----------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

  localparam int COEF_WIDTH_DEF  = 18;
  localparam int STATE_WIDTH_DEF = 32;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int REG_IDX_W = 3;
  localparam int COEF_FRAC = 14;
  localparam int IN_FRAC   = 8;
  localparam int SPAN_W    = 49;
  localparam int SPLIT     = 24;
  localparam int OPND_W    = SPAN_W - SPLIT;
  localparam int TOP_SHIFT = SPLIT - COEF_FRAC;
  localparam int WIDE_W    = 64;
  localparam int MRES_W    = 62;

  localparam int GAIN_RST   = 4069;
  localparam int NUM_B0_RST = 16384;
  localparam int NUM_B1_RST = 32768;
  localparam int NUM_B2_RST = 16384;
  localparam int DEN_A1_RST = -3018;
  localparam int DEN_A2_RST = 2909;

  localparam logic signed [WIDE_W-1:0] LIM_PART = 64'sh0004_0000_0000_0000;
  localparam logic signed [WIDE_W-1:0] LIM_MUL  = 64'sh1000_0000_0000_0000;
  localparam logic signed [WIDE_W-1:0] LIM_ACC  = 64'sh0000_8000_0000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN,
    REG_NUM_B0,
    REG_NUM_B1,
    REG_NUM_B2,
    REG_DEN_A1,
    REG_DEN_A2
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_A1,
    OP_A2,
    OP_B1,
    OP_B2,
    OP_B0,
    OP_GAIN
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_SUM,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic ld_lo;
    logic ld_hi;
    logic ld_sum;
  } mul_ctl_t;

  function automatic logic signed [WIDE_W-1:0] clamp_wide(
    input logic signed [WIDE_W-1:0] v,
    input logic signed [WIDE_W-1:0] lim
  );
    logic signed [WIDE_W-1:0] r;
    if (v < -lim) begin
      r = -lim;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bq_mulrnd.sv =====
// ----------------------------------------------------------------------------
// bq_mulrnd
// Shared multiply-and-round unit: coef * span / 2^14, rounded, in two
// half-width products (low 24 bits of span, then the high part).
// ----------------------------------------------------------------------------
`default_nettype none

module bq_mulrnd import bq_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire mul_ctl_t                  ctl,
  input  wire logic signed [COEF_WIDTH-1:0] coef,
  input  wire logic signed [SPAN_W-1:0]  span,
  output logic signed [MRES_W-1:0]       mres
);

  localparam int PROD_W = COEF_WIDTH + OPND_W;
  localparam int LOW_W  = PROD_W - COEF_FRAC;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (COEF_FRAC - 1));

  logic signed [OPND_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [LOW_W-1:0]  lowr;
  logic signed [WIDE_W-1:0] top;
  logic signed [WIDE_W-1:0] total;

  assign opnd    = ctl.ld_hi ? $signed(span[SPAN_W-1:SPLIT])
                             : $signed({1'b0, span[SPLIT-1:0]});
  assign rnd_sum = prod + RND_HALF;
  assign top     = clamp_wide(WIDE_W'(prod), LIM_PART) <<< TOP_SHIFT;
  assign total   = top + WIDE_W'(lowr);

  always_ff @(posedge clk) begin
    if (ctl.ld_lo || ctl.ld_hi) begin
      prod <= coef * opnd;
    end
    if (ctl.ld_hi) begin
      lowr <= $signed(rnd_sum[PROD_W-1:COEF_FRAC]);
    end
    if (ctl.ld_sum) begin
      mres <= MRES_W'(clamp_wide(total, LIM_MUL));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/biquad_iir_direct_form_two.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_direct_form_two
// Second-order IIR section, direct form II, fixed point, one shared multiplier.
// ----------------------------------------------------------------------------
// A sample is taken in the idle state. The block is then busy (src_stall high)
// until the result is loaded into the output register, and takes no new
// input in that time. The single shared multiplier works the six
// coefficient products one after another, each formed as two half-width
// products (low, high) and a sum state that adds the rounded parts; a state to
// clamp the numerator sum comes before the gain product, and an output state
// rounds and loads the output register. A finished sample waits in the output register while
// the next input is taken. Coefficients are signed Q3.14. The user must write them
// only while the block is idle; the block itself does not enforce it. cfg_ready is always high.
`default_nettype none

module biquad_iir_direct_form_two import bq_pkg::*; #(
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             src_valid,
  output logic                            src_stall,
  input  wire logic signed [IN_W-1:0]     sample_in,
  output logic                            dst_valid,
  input  wire                             dst_stall,
  output logic signed [OUT_W-1:0]         sample_out,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [REG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_WIDTH-1:0]      cfg_data
);

  localparam logic signed [WIDE_W-1:0] ST_MAX =
    {{(WIDE_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] ST_MIN  = ~ST_MAX;
  localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [WIDE_W-1:0] OUT_RND = WIDE_W'(1 << (IN_FRAC - 1));

  state_t state, state_next;
  op_t    op;

  logic signed [COEF_WIDTH-1:0] gain, num_b0, num_b1, num_b2, den_a1, den_a2;
  logic signed [IN_W-1:0]         x_reg;
  logic signed [STATE_WIDTH-1:0]  d1, d2, w0;
  logic signed [WIDE_W-1:0]       accw, accn;
  logic signed [SPAN_W-1:0]       acc_op;

  mul_ctl_t                    mctl;
  logic signed [COEF_WIDTH-1:0] coef;
  logic signed [SPAN_W-1:0]    span;
  logic signed [MRES_W-1:0]    mres;
  logic signed [WIDE_W-1:0]    mres_w;
  logic signed [WIDE_W-1:0]    w0_sat;
  logic signed [WIDE_W-1:0]    y_shift;
  logic signed [WIDE_W-1:0]    y_sat;
  logic                        in_take;
  logic                        out_load;

  assign cfg_ready = 1'b1;
  assign mres_w    = WIDE_W'(mres);
  assign w0_sat    = (accw > ST_MAX) ? ST_MAX : ((accw < ST_MIN) ? ST_MIN : accw);
  assign y_shift   = (mres_w + OUT_RND) >>> IN_FRAC;
  assign y_sat     = (y_shift > OUT_MAX) ? OUT_MAX
                   : ((y_shift < OUT_MIN) ? OUT_MIN : y_shift);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= COEF_WIDTH'(GAIN_RST);
      num_b0 <= COEF_WIDTH'(NUM_B0_RST);
      num_b1 <= COEF_WIDTH'(NUM_B1_RST);
      num_b2 <= COEF_WIDTH'(NUM_B2_RST);
      den_a1 <= COEF_WIDTH'(DEN_A1_RST);
      den_a2 <= COEF_WIDTH'(DEN_A2_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN:   gain   <= $signed(cfg_data);
        REG_NUM_B0: num_b0 <= $signed(cfg_data);
        REG_NUM_B1: num_b1 <= $signed(cfg_data);
        REG_NUM_B2: num_b2 <= $signed(cfg_data);
        REG_DEN_A1: den_a1 <= $signed(cfg_data);
        REG_DEN_A2: den_a2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (src_valid) state_next = S_LO;
      S_LO:   state_next = S_HI;
      S_HI:   state_next = S_SUM;
      S_SUM: begin
        if (op == OP_B0) begin
          state_next = S_ACC;
        end else if (op == OP_GAIN) begin
          state_next = S_OUT;
        end else begin
          state_next = S_LO;
        end
      end
      S_ACC:  state_next = S_LO;
      S_OUT:  if (!dst_valid || !dst_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mctl      = '0;
    src_stall = 1'b1;
    in_take   = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        src_stall = 1'b0;
        in_take   = src_valid;
      end
      S_LO:   mctl.ld_lo  = 1'b1;
      S_HI:   mctl.ld_hi  = 1'b1;
      S_SUM:  mctl.ld_sum = 1'b1;
      S_ACC: ;
      S_OUT:  out_load = !dst_valid || !dst_stall;
      default: ;
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    unique case (op)
      OP_A1: begin
        coef = den_a1;
        span = SPAN_W'(d1);
      end
      OP_A2: begin
        coef = den_a2;
        span = SPAN_W'(d2);
      end
      OP_B1: begin
        coef = num_b1;
        span = SPAN_W'(d1);
      end
      OP_B2: begin
        coef = num_b2;
        span = SPAN_W'(d2);
      end
      OP_B0: begin
        coef = num_b0;
        span = SPAN_W'(w0);
      end
      default: begin
        coef = gain;
        span = acc_op;
      end
    endcase
  end

  bq_mulrnd #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mulrnd (
    .clk  (clk),
    .ctl  (mctl),
    .coef (coef),
    .span (span),
    .mres (mres)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_A1;
      dst_valid <= 1'b0;
      d1        <= '0;
      d2        <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        op <= OP_A1;
      end else if (state == S_SUM && op != OP_B0 && op != OP_GAIN) begin
        op <= op_t'(op + 3'd1);
      end else if (state == S_ACC) begin
        op <= OP_GAIN;
      end
      if (out_load) begin
        dst_valid <= 1'b1;
        d2        <= d1;
        d1        <= w0;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  // datapath registers; a product is folded in during the low-half cycle of
  // the next one, the b0 product in S_ACC and the gain product in S_OUT
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_reg <= sample_in;
    end
    if (state == S_LO) begin
      unique case (op)
        OP_A2: accw <= (WIDE_W'(x_reg) <<< IN_FRAC) - mres_w;
        OP_B1: accw <= accw - mres_w;
        OP_B2: begin
          w0   <= STATE_WIDTH'(w0_sat);
          accn <= mres_w;
        end
        OP_B0: accn <= accn + mres_w;
        default: ;
      endcase
    end
    if (state == S_ACC) begin
      acc_op <= SPAN_W'(clamp_wide(accn + mres_w, LIM_ACC));
    end
    if (out_load) begin
      sample_out <= OUT_W'(y_sat);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bq_checker.sv =====
// ----------------------------------------------------------------------------
// bq_checker
// Port-level checks of the biquad section, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bq_checker import bq_pkg::*; (
  input wire                         clk,
  input wire                         rst,
  input wire                         src_valid,
  input wire                         src_stall,
  input wire                         dst_valid,
  input wire                         dst_stall,
  input wire logic signed [OUT_W-1:0] sample_out
);

  // block goes busy right after taking a sample
  `ASSERT_CLK(a_busy_after_take, clk, rst, src_valid && !src_stall |=> src_stall)

  // a new result only shows up at the end of a busy period
  `ASSERT_CLK(a_result_after_work, clk, rst, $rose(dst_valid) |-> $past(src_stall))

  // reset empties the output register
  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> !dst_valid)

  // held result transaction keeps its data
  `ASSERT_CLK(a_out_hold, clk, rst,
    dst_valid && dst_stall |=> dst_valid && $stable(sample_out))

endmodule

bind biquad_iir_direct_form_two bq_checker u_bq_checker (.*);

`default_nettype wire

// ===== dv/biquad_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_checker
// Passive monitor for the biquad section. It follows every register write,
// keeps its own copy of the coefficients and the two delay elements, works out
// the output sample for each accepted input transaction, and compares every
// accepted output transaction with the oldest sample still owed.
// ----------------------------------------------------------------------------
module biquad_checker import bq_pkg::*; #(
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         src_valid,
  input  wire                         src_stall,
  input  wire logic signed [IN_W-1:0]  sample_in,
  input  wire                         dst_valid,
  input  wire                         dst_stall,
  input  wire logic signed [OUT_W-1:0] sample_out,
  input  wire                         cfg_valid,
  input  wire                         cfg_ready,
  input  wire logic [REG_IDX_W-1:0]    cfg_index,
  input  wire logic [COEF_WIDTH-1:0]   cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);

  localparam longint W_MAX = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
  localparam longint W_MIN = -W_MAX - 1;
  localparam longint Y_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;

  longint gain_q, b0_q, b1_q, b2_q, a1_q, a2_q;
  longint w1, w2;
  logic signed [OUT_W-1:0] owed_samples[$];
  logic signed [OUT_W-1:0] owed;

  function automatic longint hold_to(input longint v, input longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // Q3.14 coefficient times a value with 8 fraction bits, rounded back to
  // 8 fraction bits; the value is split so each partial product stays narrow.
  function automatic longint coef_mul(input longint coef, input longint v);
    longint upper, lower, upper_prod, lower_prod;
    upper      = v >>> SPLIT;
    lower      = v - (upper <<< SPLIT);
    upper_prod = hold_to(coef * upper, LIM_PART) <<< TOP_SHIFT;
    lower_prod = (coef * lower + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    return hold_to(upper_prod + lower_prod, LIM_MUL);
  endfunction

  function automatic logic signed [OUT_W-1:0] filter_step(
    input logic signed [IN_W-1:0] x
  );
    longint w0, acc, y;
    w0  = (longint'(x) <<< IN_FRAC) - coef_mul(a1_q, w1) - coef_mul(a2_q, w2);
    w0  = (w0 > W_MAX) ? W_MAX : ((w0 < W_MIN) ? W_MIN : w0);
    acc = hold_to(coef_mul(b0_q, w0) + coef_mul(b1_q, w1) + coef_mul(b2_q, w2),
                  LIM_ACC);
    y   = (coef_mul(gain_q, acc) + (longint'(1) <<< (IN_FRAC - 1))) >>> IN_FRAC;
    y   = (y > Y_MAX) ? Y_MAX : ((y < Y_MIN) ? Y_MIN : y);
    w2  = w1;
    w1  = w0;
    return y[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_q = GAIN_RST;
      b0_q   = NUM_B0_RST;
      b1_q   = NUM_B1_RST;
      b2_q   = NUM_B2_RST;
      a1_q   = DEN_A1_RST;
      a2_q   = DEN_A2_RST;
      w1     = 0;
      w2     = 0;
      owed_samples.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:   gain_q = longint'($signed(cfg_data));
          REG_NUM_B0: b0_q   = longint'($signed(cfg_data));
          REG_NUM_B1: b1_q   = longint'($signed(cfg_data));
          REG_NUM_B2: b2_q   = longint'($signed(cfg_data));
          REG_DEN_A1: a1_q   = longint'($signed(cfg_data));
          REG_DEN_A2: a2_q   = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (dst_valid && !dst_stall) begin
        if (owed_samples.size() == 0) begin
          fail_count++;
          $error("sample_out: transaction with none owed, actual %0d", sample_out);
        end else begin
          owed = owed_samples.pop_front();
          checked++;
          if (sample_out !== owed) begin
            fail_count++;
            $error("sample_out mismatch: expected %0d, actual %0d", owed, sample_out);
          end
        end
      end
      if (src_valid && !src_stall) begin
        owed_samples.push_back(filter_step(sample_in));
      end
      pending = owed_samples.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the biquad section: directed saturation corners, then phases of
// random samples under extreme, stable, random and default coefficient sets,
// with random stalls on both channels. Checking lives in biquad_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bq_pkg::*;

  localparam int     COEF_W        = COEF_WIDTH_DEF;
  localparam longint COEF_MAX      = (longint'(1) <<< (COEF_W - 1)) - 1;
  localparam longint COEF_MIN      = -COEF_MAX - 1;
  localparam logic signed [IN_W-1:0] SAMPLE_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] SAMPLE_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam int     PHASES        = 12;
  localparam int     PHASE_ITEMS   = 119;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 24;
  localparam int     CYCLE_LIMIT   = 600000;

  logic                     clk;
  logic                     rst;
  logic                     src_valid;
  logic                     src_stall;
  logic signed [IN_W-1:0]   sample_in;
  logic                     dst_valid;
  logic                     dst_stall;
  logic signed [OUT_W-1:0]  sample_out;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [REG_IDX_W-1:0]     cfg_index;
  logic [COEF_W-1:0]        cfg_data;

  int fail_count, pending, checked;
  int sent, coef_sets, hold_req, hold_seen;
  bit rx_quiet, tx_gapless;

  biquad_iir_direct_form_two u_dut (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .sample_in  (sample_in),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  biquad_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .sample_in  (sample_in),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  function automatic longint pick_any();
    return longint'($urandom_range(0, 32'(2 * COEF_MAX + 1))) + COEF_MIN;
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(0, 3))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return 0;
      default: return pick_any();
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] rand_sample(input bit low_level);
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return SAMPLE_MAX;
    if (sel == 1) return SAMPLE_MIN;
    if (sel == 2) return '0;
    if (sel == 3) return ($urandom_range(0, 1) != 0) ? IN_W'(1) : IN_W'(-1);
    if (low_level && sel < 10) return IN_W'(int'($urandom_range(0, 511)) - 256);
    return IN_W'($urandom);
  endfunction

  // output side: random stalls, plus one long hold-off on request
  initial begin
    dst_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        dst_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        dst_stall <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        dst_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        dst_stall <= 1'b0;
      end
    end
  end

  task automatic push_sample(input logic signed [IN_W-1:0] v);
    src_valid <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    sent++;
  endtask

  task automatic src_pause(input int n);
    src_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_results();
    src_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[COEF_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stray: also hit the unused indexes, which must leave every register alone
  task automatic load_coefs(input longint g, b0, b1, b2, a1, a2, input bit stray);
    put_reg(REG_GAIN, g);
    put_reg(REG_NUM_B0, b0);
    put_reg(REG_NUM_B1, b1);
    put_reg(REG_NUM_B2, b2);
    put_reg(REG_DEN_A1, a1);
    put_reg(REG_DEN_A2, a2);
    if (stray) begin
      put_reg(REG_IDX_W'(REG_DEN_A2 + 1), longint'($urandom));
      put_reg(REG_IDX_W'(REG_DEN_A2 + 2), longint'($urandom));
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    coef_sets++;
  endtask

  // poles inside the stability triangle, so the delay line stays in range
  task automatic load_stable_filter();
    longint a1, a2, span;
    a2   = longint'($urandom_range(0, 28000)) - 14000;
    span = 16384 + a2 - 1;
    a1   = longint'($urandom_range(0, 32'(2 * span))) - span;
    load_coefs(longint'($urandom_range(0, 32768)) - 16384,
               longint'($urandom_range(0, 65536)) - 32768,
               longint'($urandom_range(0, 65536)) - 32768,
               longint'($urandom_range(0, 65536)) - 32768,
               a1, a2, 1'b0);
  endtask

  initial begin
    rst        <= 1'b1;
    src_valid  <= 1'b0;
    sample_in  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rx_quiet   = 1'b1;
    tx_gapless = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_sample('0);
    repeat (3) push_sample(SAMPLE_MAX);
    repeat (2) push_sample(SAMPLE_MIN);
    push_sample(IN_W'(1));
    push_sample(IN_W'(-1));
    wait_results();

    // strong feedback: delay saturation, numerator clamp, output clipping
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, 1'b1);
    repeat (5) push_sample(SAMPLE_MAX);
    repeat (3) push_sample(SAMPLE_MIN);
    wait_results();

    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN, 1'b0);
    repeat (3) push_sample(SAMPLE_MIN);
    repeat (3) push_sample(SAMPLE_MAX);
    wait_results();

    for (int p = 0; p < PHASES; p++) begin
      rx_quiet   = (p % 3 == 0);
      tx_gapless = (p % 3 == 1);
      case (p % 4)
        0: load_coefs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), 1'b1);
        1: load_stable_filter();
        2: load_coefs(pick_any(), pick_any(), pick_any(), pick_any(),
                      pick_any(), pick_any(), 1'b1);
        default: load_coefs(pick_any(), longint'(NUM_B0_RST), longint'(NUM_B1_RST),
                            longint'(NUM_B2_RST), longint'(DEN_A1_RST),
                            longint'(DEN_A2_RST), 1'b0);
      endcase
      if (p == 1) hold_req++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) wait_results();
        push_sample(rand_sample(p % 4 == 1));
        if (!tx_gapless && $urandom_range(0, 3) == 0) src_pause(gap_len());
      end
      wait_results();
    end

    $display("Covered %0d samples (%0d checked) over %0d coefficient sets,", sent, checked,
             coef_sets);
    $display("with saturation corners, unused register writes and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
